// ----- sv/assert_macros.svh -----
// Assertion macros used by the handle table controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("assertion failed");

// expression that must never be true out of reset
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition seen");

`endif

// ----- sv/ght_pkg.sv -----
// Types and constants of the generational handle table
package ght_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int AGE_BITS    = 6;
	localparam int OBJECT_BITS = 32;
	localparam int SLOT_COUNT  = 1 << INDEX_BITS;

	localparam logic [INDEX_BITS-1:0] LAST_SLOT = '1;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NULL   = 2'd1;
	localparam logic [1:0] STATUS_NOSLOT = 2'd2;
	localparam logic [1:0] STATUS_STALE  = 2'd3;

	localparam logic [1:0] BR_NONE   = 2'd0;
	localparam logic [1:0] BR_RECORD = 2'd1;
	localparam logic [1:0] BR_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [INDEX_BITS-1:0]  handle_index;
		logic [AGE_BITS-1:0]    handle_age;
		logic [OBJECT_BITS-1:0] object_id;
		logic                   object_has_slot;
		logic [INDEX_BITS-1:0]  object_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [INDEX_BITS-1:0]  out_index;
		logic [AGE_BITS-1:0]    out_age;
		logic [OBJECT_BITS-1:0] out_object;
		logic [1:0]             back_ref_action;
	} rsp_t;

	typedef struct packed {
		logic                in_use;
		logic [AGE_BITS-1:0] age;
	} slot_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// ----- sv/ght_ctrl.sv -----
// Controller of the handle table: clearing pass, request sequencing, result valid
`include "assert_macros.svh"

module ght_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  ght_pkg::dp_status_t dp_status,
	output ght_pkg::ctrl_cmd_t  ctrl_cmd
);

	ght_pkg::state_t state_q, state_d;
	logic            rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ght_pkg::S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		ctrl_cmd          = '0;
		req_stall         = 1'b1;
		rsp_valid_d       = rsp_valid_q && rsp_stall;
		unique case (state_q)
			ght_pkg::S_CLEAR: begin
				ctrl_cmd.clear_wr = 1'b1;
				if (dp_status.clear_done) begin
					state_d = ght_pkg::S_IDLE;
				end
			end
			ght_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctrl_cmd.load = 1'b1;
					state_d       = ght_pkg::S_EXEC;
				end
			end
			ght_pkg::S_EXEC: begin
				if (!rsp_valid_q || !rsp_stall) begin
					ctrl_cmd.commit = 1'b1;
					rsp_valid_d     = 1'b1;
					state_d         = ght_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ght_pkg::S_CLEAR;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	`ASSERT_NEVER(a_commit_during_clear, ctrl_cmd.commit && ctrl_cmd.clear_wr)
	`ASSERT_CLK(a_commit_shows_result, ctrl_cmd.commit |=> rsp_valid)
	`ASSERT_CLK(a_no_back_to_back_load, ctrl_cmd.load |=> !ctrl_cmd.load)

endmodule

// ----- sv/ght_datapath.sv -----
// Datapath of the handle table: slot memories, free list pointers, result register
module ght_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ght_pkg::req_t       req,
	input  ght_pkg::ctrl_cmd_t  ctrl_cmd,
	output ght_pkg::dp_status_t dp_status,
	output ght_pkg::rsp_t       rsp
);

	ght_pkg::slot_t                  slot_mem [ght_pkg::SLOT_COUNT];
	logic [ght_pkg::INDEX_BITS-1:0]  next_mem [ght_pkg::SLOT_COUNT];
	logic [ght_pkg::OBJECT_BITS-1:0] obj_mem  [ght_pkg::SLOT_COUNT];

	ght_pkg::req_t                   req_s1;
	ght_pkg::slot_t                  rda_s1, rdb_s1;
	logic [ght_pkg::INDEX_BITS-1:0]  nf_s1;
	logic [ght_pkg::OBJECT_BITS-1:0] obj_s1;
	ght_pkg::rsp_t                   rsp_q, rsp_d;

	logic [ght_pkg::INDEX_BITS-1:0] free_head_q, free_tail_q, clr_cnt_q;
	logic                           free_empty_q;
	logic [ght_pkg::INDEX_BITS-1:0] head_d, tail_d;
	logic                           empty_d;
	logic [ght_pkg::INDEX_BITS:0]   cnt_inc;
	logic [ght_pkg::AGE_BITS:0]     age_inc;
	logic [ght_pkg::INDEX_BITS-1:0] rda_addr;

	logic                           ex_slot_we, ex_next_we, ex_obj_we;
	logic [ght_pkg::INDEX_BITS-1:0] ex_slot_addr;
	ght_pkg::slot_t                 ex_slot_data;

	logic                           slot_we, next_we, obj_we;
	logic [ght_pkg::INDEX_BITS-1:0] slot_waddr, next_waddr, next_wdata;
	ght_pkg::slot_t                 slot_wdata;

	assign cnt_inc  = {1'b0, clr_cnt_q} + 1'b1;
	assign age_inc  = {1'b0, rdb_s1.age} + 1'b1;
	assign rda_addr = (req.cmd == ght_pkg::CMD_CREATE) ? req.object_slot : req.handle_index;

	always_ff @(posedge clk) begin
		if (ctrl_cmd.load) begin
			req_s1 <= req;
			rda_s1 <= slot_mem[rda_addr];
			rdb_s1 <= slot_mem[free_head_q];
			nf_s1  <= next_mem[free_head_q];
			obj_s1 <= obj_mem[req.handle_index];
		end
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (obj_we) begin
			obj_mem[free_head_q] <= req_s1.object_id;
		end
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ght_pkg::STATUS_NULL;
		ex_slot_we   = 1'b0;
		ex_next_we   = 1'b0;
		ex_obj_we    = 1'b0;
		ex_slot_addr = req_s1.handle_index;
		ex_slot_data = rda_s1;
		head_d       = free_head_q;
		tail_d       = free_tail_q;
		empty_d      = free_empty_q;
		case (req_s1.cmd) inside
			ght_pkg::CMD_CREATE: begin
				if (req_s1.object_id == '0) begin
					rsp_d.status = ght_pkg::STATUS_NULL;
				end else if (req_s1.object_has_slot &&
						(req_s1.object_slot != '0 || rda_s1.age != '0)) begin
					rsp_d.status    = ght_pkg::STATUS_OK;
					rsp_d.out_index = req_s1.object_slot;
					rsp_d.out_age   = rda_s1.age;
				end else if (free_empty_q) begin
					rsp_d.status = ght_pkg::STATUS_NOSLOT;
				end else begin
					rsp_d.status          = ght_pkg::STATUS_OK;
					rsp_d.out_index       = free_head_q;
					rsp_d.out_age         = age_inc[ght_pkg::AGE_BITS-1:0];
					rsp_d.back_ref_action = ght_pkg::BR_RECORD;
					ex_slot_we            = 1'b1;
					ex_slot_addr          = free_head_q;
					ex_slot_data.in_use   = 1'b1;
					ex_slot_data.age      = age_inc[ght_pkg::AGE_BITS-1:0];
					ex_obj_we             = 1'b1;
					if (free_head_q == free_tail_q) begin
						empty_d = 1'b1;
					end else begin
						head_d = nf_s1;
					end
				end
			end
			ght_pkg::CMD_DESTROY, ght_pkg::CMD_LOOKUP: begin
				if (req_s1.handle_index == '0 && req_s1.handle_age == '0) begin
					rsp_d.status = ght_pkg::STATUS_NULL;
				end else if (!rda_s1.in_use || rda_s1.age != req_s1.handle_age) begin
					rsp_d.status = ght_pkg::STATUS_STALE;
				end else begin
					rsp_d.status     = ght_pkg::STATUS_OK;
					rsp_d.out_index  = req_s1.handle_index;
					rsp_d.out_age    = req_s1.handle_age;
					rsp_d.out_object = obj_s1;
					if (req_s1.cmd == ght_pkg::CMD_DESTROY) begin
						rsp_d.back_ref_action = ght_pkg::BR_CLEAR;
						ex_slot_we            = 1'b1;
						ex_slot_data.in_use   = 1'b0;
						tail_d                = req_s1.handle_index;
						if (free_empty_q) begin
							head_d  = req_s1.handle_index;
							empty_d = 1'b0;
						end else begin
							ex_next_we = 1'b1;
						end
					end
				end
			end
			default: begin
				rsp_d.status = ght_pkg::STATUS_NULL;
			end
		endcase
	end

	always_comb begin
		slot_we    = ctrl_cmd.clear_wr || (ctrl_cmd.commit && ex_slot_we);
		next_we    = ctrl_cmd.clear_wr || (ctrl_cmd.commit && ex_next_we);
		obj_we     = ctrl_cmd.commit && ex_obj_we;
		slot_waddr = ctrl_cmd.clear_wr ? clr_cnt_q : ex_slot_addr;
		slot_wdata = ctrl_cmd.clear_wr ? '0 : ex_slot_data;
		next_waddr = ctrl_cmd.clear_wr ? clr_cnt_q : free_tail_q;
		if (ctrl_cmd.clear_wr) begin
			next_wdata = (clr_cnt_q == ght_pkg::LAST_SLOT) ? clr_cnt_q :
				cnt_inc[ght_pkg::INDEX_BITS-1:0];
		end else begin
			next_wdata = req_s1.handle_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			free_tail_q  <= ght_pkg::LAST_SLOT;
			free_empty_q <= 1'b0;
			clr_cnt_q    <= '0;
		end else begin
			if (ctrl_cmd.clear_wr) begin
				clr_cnt_q <= cnt_inc[ght_pkg::INDEX_BITS-1:0];
			end
			if (ctrl_cmd.commit) begin
				free_head_q  <= head_d;
				free_tail_q  <= tail_d;
				free_empty_q <= empty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign dp_status.clear_done = (clr_cnt_q == ght_pkg::LAST_SLOT);
	assign rsp                  = rsp_q;

endmodule

// ----- sv/generational_handle_table.sv -----
// Top level of the generational handle table
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------
//  request | req_valid / req_stall      | req (req_t)
//  result  | rsp_valid / rsp_stall      | rsp (rsp_t)
//
// After reset a clearing pass initialises the slot tables; req_stall is high.
// Each request then goes through accept, with the registered table memory reads, and then execute.
// The execute cycle writes the slot, next-free and object memories and the result register.
// A result waiting under rsp_stall holds the next request in execute until it is taken.
module generational_handle_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ght_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ght_pkg::rsp_t rsp
);

	ght_pkg::ctrl_cmd_t  ctrl_cmd;
	ght_pkg::dp_status_t dp_status;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.dp_status (dp_status),
		.ctrl_cmd  (ctrl_cmd)
	);

	ght_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctrl_cmd  (ctrl_cmd),
		.dp_status (dp_status),
		.rsp       (rsp)
	);

endmodule

// ----- tb/generational_handle_table_tb.sv -----
// Self-checking testbench of the generational handle table: predicted results against the block
module generational_handle_table_tb;

	typedef logic [ght_pkg::INDEX_BITS-1:0]  index_t;
	typedef logic [ght_pkg::AGE_BITS-1:0]    age_t;
	typedef logic [ght_pkg::OBJECT_BITS-1:0] object_t;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ght_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ght_pkg::rsp_t rsp;

	generational_handle_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// shadow of the slot tables and free list
	age_t    ages [ght_pkg::SLOT_COUNT];
	bit      in_use [ght_pkg::SLOT_COUNT];
	index_t  next_free [ght_pkg::SLOT_COUNT];
	object_t objects [ght_pkg::SLOT_COUNT];
	index_t  free_head = '0;
	index_t  free_tail = ght_pkg::LAST_SLOT;
	bit      free_empty = 1'b0;

	initial begin
		for (int i = 0; i < ght_pkg::SLOT_COUNT; i++) begin
			ages[i] = '0;
			in_use[i] = 1'b0;
			next_free[i] = (i == ght_pkg::SLOT_COUNT - 1) ? index_t'(i) : index_t'(i + 1);
			objects[i] = '0;
		end
	end

	ght_pkg::req_t pending_requests [$];
	ght_pkg::rsp_t expected_results [$];
	int requests_sent = 0;
	int requests_taken = 0;
	int mismatches = 0;
	bit quiet = 1'b0;

	task automatic predict_handle_result(input ght_pkg::req_t r, output ght_pkg::rsp_t e);
		index_t s;
		age_t a;
		e = '0;
		e.status = ght_pkg::STATUS_NULL;
		e.back_ref_action = ght_pkg::BR_NONE;
		case (r.cmd)
			ght_pkg::CMD_CREATE: begin
				if (r.object_id == '0) begin
				end else if (r.object_has_slot &&
						(r.object_slot != '0 || ages[r.object_slot] != '0)) begin
					e.status = ght_pkg::STATUS_OK;
					e.out_index = r.object_slot;
					e.out_age = ages[r.object_slot];
				end else if (free_empty) begin
					e.status = ght_pkg::STATUS_NOSLOT;
				end else begin
					s = free_head;
					a = ages[s] + 1'b1;
					ages[s] = a;
					in_use[s] = 1'b1;
					objects[s] = r.object_id;
					if (next_free[s] == s)
						free_empty = 1'b1;
					else
						free_head = next_free[s];
					e.status = ght_pkg::STATUS_OK;
					e.out_index = s;
					e.out_age = a;
					e.back_ref_action = ght_pkg::BR_RECORD;
				end
			end
			ght_pkg::CMD_DESTROY, ght_pkg::CMD_LOOKUP: begin
				if (r.handle_index == '0 && r.handle_age == '0) begin
				end else if (!in_use[r.handle_index] ||
						ages[r.handle_index] != r.handle_age) begin
					e.status = ght_pkg::STATUS_STALE;
				end else begin
					e.status = ght_pkg::STATUS_OK;
					e.out_index = r.handle_index;
					e.out_age = r.handle_age;
					e.out_object = objects[r.handle_index];
					if (r.cmd == ght_pkg::CMD_DESTROY) begin
						e.back_ref_action = ght_pkg::BR_CLEAR;
						in_use[r.handle_index] = 1'b0;
						objects[r.handle_index] = '0;
						if (free_empty) begin
							free_head = r.handle_index;
							free_empty = 1'b0;
						end else begin
							next_free[free_tail] = r.handle_index;
						end
						next_free[r.handle_index] = r.handle_index;
						free_tail = r.handle_index;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	int send_gap = 0;

	always @(posedge clk) begin : drive_requests
		ght_pkg::rsp_t predicted;
		logic taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			taken = req_valid && !req_stall;
			if (taken) begin
				predict_handle_result(req, predicted);
				expected_results.push_back(predicted);
				requests_taken++;
			end
			if (send_gap > 0)
				send_gap--;
			else if (!quiet && $urandom_range(0, 24) == 0)
				send_gap = $urandom_range(1, 13);
			if (req_valid && !taken) begin
			end else if (send_gap == 0 && pending_requests.size() != 0) begin
				req <= pending_requests.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	int hold_gap = 0;

	always @(posedge clk) begin : check_results
		ght_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request pending", '0, rsp);
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", want.status, rsp.status);
					if (rsp.out_index !== want.out_index)
						report_mismatch("out_index", want.out_index, rsp.out_index);
					if (rsp.out_age !== want.out_age)
						report_mismatch("out_age", want.out_age, rsp.out_age);
					if (rsp.out_object !== want.out_object)
						report_mismatch("out_object", want.out_object, rsp.out_object);
					if (rsp.back_ref_action !== want.back_ref_action)
						report_mismatch("back_ref_action", want.back_ref_action,
							rsp.back_ref_action);
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 24) == 0) begin
				hold_gap = $urandom_range(1, 13) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic object_t fresh_object();
		object_t o;
		o = object_t'($urandom);
		if (o == '0)
			o = object_t'(1);
		return o;
	endfunction

	function automatic ght_pkg::req_t create_request(object_t obj, logic has_slot,
			index_t slot);
		ght_pkg::req_t r;
		r.cmd = ght_pkg::CMD_CREATE;
		r.handle_index = index_t'($urandom);
		r.handle_age = age_t'($urandom);
		r.object_id = obj;
		r.object_has_slot = has_slot;
		r.object_slot = slot;
		return r;
	endfunction

	function automatic ght_pkg::req_t handle_request(logic [1:0] c, index_t idx, age_t age);
		ght_pkg::req_t r;
		r.cmd = c;
		r.handle_index = idx;
		r.handle_age = age;
		r.object_id = object_t'($urandom);
		r.object_has_slot = 1'($urandom);
		r.object_slot = index_t'($urandom);
		return r;
	endfunction

	function automatic int find_live_slot();
		int start;
		int s;
		start = $urandom_range(0, ght_pkg::SLOT_COUNT - 1);
		for (int i = 0; i < ght_pkg::SLOT_COUNT; i++) begin
			s = (start + i) % ght_pkg::SLOT_COUNT;
			if (in_use[s])
				return s;
		end
		return -1;
	endfunction

	task automatic push_request(input ght_pkg::req_t r);
		pending_requests.push_back(r);
		requests_sent++;
	endtask

	task automatic settle();
		while (requests_taken != requests_sent)
			@(negedge clk);
	endtask

	task automatic random_request(input int create_weight);
		int roll;
		int sub;
		int s;
		logic [1:0] c;
		ght_pkg::req_t r;
		while (pending_requests.size() > 2)
			@(negedge clk);
		roll = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		s = find_live_slot();
		if (roll < 3) begin
			r = ght_pkg::req_t'({$urandom, $urandom});
			r.cmd = CMD_UNUSED;
		end else if (roll < create_weight) begin
			if (sub < 3)
				r = create_request('0, 1'($urandom), index_t'($urandom));
			else if (sub < 13 && s >= 0)
				r = create_request(objects[s], 1'b1, index_t'(s));
			else if (sub < 18)
				r = create_request(fresh_object(), 1'b1, index_t'($urandom));
			else
				r = create_request(fresh_object(), 1'b0, index_t'($urandom));
		end else begin
			c = $urandom_range(0, 1) ? ght_pkg::CMD_DESTROY : ght_pkg::CMD_LOOKUP;
			if (sub < 5)
				r = handle_request(c, '0, '0);
			else if (sub < 15 || s < 0)
				r = handle_request(c, index_t'($urandom), age_t'($urandom));
			else if (sub < 25)
				r = handle_request(c, index_t'(s),
					ages[s] ^ age_t'($urandom_range(1, (1 << ght_pkg::AGE_BITS) - 1)));
			else
				r = handle_request(c, index_t'(s), ages[s]);
		end
		push_request(r);
	endtask

	initial begin : stimulus
		int f;
		push_request(create_request(object_t'(1), 1'b1, '0));
		push_request(create_request('1, 1'b0, ght_pkg::LAST_SLOT));
		push_request(create_request(object_t'(32'hA5A5_5A5A), 1'b1, index_t'(1)));
		push_request(create_request('0, 1'b0, '0));
		push_request(create_request(object_t'(32'h1234), 1'b1, ght_pkg::LAST_SLOT));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, '0, '0));
		push_request(handle_request(ght_pkg::CMD_DESTROY, '0, '0));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, '0, age_t'(1)));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, index_t'(1), age_t'(1)));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, ght_pkg::LAST_SLOT, '1));
		push_request(handle_request(ght_pkg::CMD_DESTROY, index_t'(1), age_t'(2)));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, index_t'(2), age_t'(1)));
		push_request(handle_request(ght_pkg::CMD_DESTROY, index_t'(1), age_t'(1)));
		push_request(handle_request(ght_pkg::CMD_DESTROY, index_t'(1), age_t'(1)));
		push_request(handle_request(ght_pkg::CMD_LOOKUP, index_t'(1), age_t'(1)));
		push_request(ght_pkg::req_t'('1));
		push_request(handle_request(CMD_UNUSED, '0, '0));
		push_request(create_request(fresh_object(), 1'b0, '0));
		push_request(handle_request(ght_pkg::CMD_DESTROY, '0, age_t'(1)));
		push_request(create_request(fresh_object(), 1'b1, '0));
		settle();

		// fill the table until the free list runs dry
		for (int n = 0; n < 2000 && !free_empty; n++) begin
			while (pending_requests.size() > 2)
				@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				random_request(96);
			else
				push_request(create_request(fresh_object(), 1'b0, index_t'($urandom)));
		end
		settle();
		while (!free_empty) begin
			push_request(create_request(fresh_object(), 1'b0, index_t'($urandom)));
			settle();
		end

		// recycle one slot on a full table until its age wraps
		f = find_live_slot();
		if (f < 0)
			f = 0;
		for (int n = 0; n < 66; n++) begin
			settle();
			if ($urandom_range(0, 3) == 0)
				push_request(handle_request(ght_pkg::CMD_LOOKUP, index_t'(f), ages[f]));
			push_request(handle_request(ght_pkg::CMD_DESTROY, index_t'(f), ages[f]));
			push_request(create_request(fresh_object(), 1'b0, index_t'($urandom)));
		end
		settle();

		for (int n = 0; n < 40; n++) begin
			if (n == 20)
				quiet = 1'b1;
			random_request(50);
		end

		settle();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
